// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the RTL folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/isrt_pkg.sv =====
// ---------------------------------------------------------------------------
// isrt_pkg
// Shared constants and types for the insertion sorter.
// ---------------------------------------------------------------------------
package isrt_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;

    // Command from the sequencer to every cell of the chain.
    typedef struct packed {
        logic ins;    // insert the incoming value
        logic shift;  // move every entry one place toward cell 0
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/isrt_cell.sv =====
// ---------------------------------------------------------------------------
// isrt_cell
// One slot of the sorted chain: holds a value and its valid bit.
// ---------------------------------------------------------------------------
module isrt_cell
    import isrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_prev_val,
    input  logic              i_prev_valid,
    input  logic              i_prev_gt,
    input  logic [DATA_W-1:0] i_next_val,
    input  logic              i_next_valid,
    output logic [DATA_W-1:0] o_val,
    output logic              o_valid,
    output logic              o_gt
);

    logic [DATA_W-1:0] r_val;
    logic              r_valid;
    logic [DATA_W-1:0] n_val;
    logic              n_valid;

    // An empty slot counts as larger than anything, so it takes the new value
    // or the one pushed up from below.
    assign o_gt = !r_valid || ($signed(r_val) > $signed(i_value));

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_val   = i_next_val;
            n_valid = i_next_valid;
        end else if (i_ctrl.ins) begin
            n_val   = i_prev_gt ? i_prev_val : (o_gt ? i_value : r_val);
            n_valid = i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_val <= n_val;
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;

endmodule

// ===== hw/rtl/insertion_sorter_core.sv =====
// Timing: an item is placed in the chain at the edge that accepts it; once the beat marked
//   last is accepted, readout begins and the first result is registered out of cell 0.
// Throughput: one input beat per cycle while loading, one result per cycle while the output
//   is not stalled in readout (n results for a set of n, at most CAPACITY); input is stalled during readout.
// Reset (synchronous, active low): clears all cell valid bits, the drop flag,
//   the output valid and returns the sequencer to loading.
// ---------------------------------------------------------------------------
// insertion_sorter_core
// Streaming insertion sort over a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module insertion_sorter_core
    import isrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [DATA_W-1:0] i_value,
    input  logic              i_last_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_sorted_value,
    output logic              o_last_out,
    output logic              o_overflow
);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic                r_dropped;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_val;
    logic                r_out_last;
    logic                r_out_ovf;

    logic [DATA_W-1:0]   w_val   [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_gt;
    t_cell_ctrl          w_ctrl;

    logic w_in_acc;
    logic w_full;
    logic w_out_free;
    logic w_emit_step;

    assign o_in_stall  = (r_state == ST_EMIT);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_full      = w_valid[CAPACITY-1];
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit_step = (r_state == ST_EMIT) && w_out_free;

    assign w_ctrl.ins   = w_in_acc && !w_full;
    assign w_ctrl.shift = w_emit_step;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] w_prev_val;
        logic              w_prev_valid;
        logic              w_prev_gt;
        logic [DATA_W-1:0] w_next_val;
        logic              w_next_valid;

        if (i == 0) begin : g_head
            assign w_prev_val   = i_value;
            assign w_prev_valid = 1'b1;
            assign w_prev_gt    = 1'b0;
        end else begin : g_body
            assign w_prev_val   = w_val[i-1];
            assign w_prev_valid = w_valid[i-1];
            assign w_prev_gt    = w_gt[i-1];
        end

        if (i == CAPACITY-1) begin : g_tail
            assign w_next_val   = i_value;
            assign w_next_valid = 1'b0;
        end else begin : g_mid
            assign w_next_val   = w_val[i+1];
            assign w_next_valid = w_valid[i+1];
        end

        isrt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_value      (i_value),
            .i_prev_val   (w_prev_val),
            .i_prev_valid (w_prev_valid),
            .i_prev_gt    (w_prev_gt),
            .i_next_val   (w_next_val),
            .i_next_valid (w_next_valid),
            .o_val        (w_val[i]),
            .o_valid      (w_valid[i]),
            .o_gt         (w_gt[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= w_emit_step;
            end
            case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (w_full) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_last_in) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    // cell 1 empty: cell 0 holds the final result of the set
                    if (w_emit_step && !w_valid[1]) begin
                        r_state   <= ST_LOAD;
                        r_dropped <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
        if (w_emit_step) begin
            r_out_val  <= w_val[0];
            r_out_last <= !w_valid[1];
            r_out_ovf  <= r_dropped;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_val;
    assign o_last_out     = r_out_last;
    assign o_overflow     = r_out_ovf;

    `ASSERT_IMP(a_valid_prefix, 1'b1, (w_valid & (w_valid + CAPACITY'(1))) == '0, "cell valid bits not a prefix")
    `ASSERT_IMP(a_emit_nonempty, r_state == ST_EMIT, w_valid[0], "readout with empty chain")
    `ASSERT_NXT(a_emit_done, w_emit_step && !w_valid[1], r_state == ST_LOAD && !r_dropped, "readout did not close the set")

    for (genvar k = 1; k < CAPACITY; k++) begin : g_chk
        `ASSERT_IMP(a_sorted, w_valid[k], $signed(w_val[k-1]) <= $signed(w_val[k]), "chain out of order")
    end

endmodule
